[rtl/servo_reply_frame_parser_macros.svh]
// assertion helpers for the servo reply frame parser
// both expect signals named clk and rst in the calling scope
`ifndef SERVO_REPLY_FRAME_PARSER_MACROS_SVH
`define SERVO_REPLY_FRAME_PARSER_MACROS_SVH

// same-cycle implication, off during reset
`define SRFP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("servo reply frame parser check failed");

// next-cycle implication, off during reset
`define SRFP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("servo reply frame parser check failed");

`endif

[rtl/srfp_pkg.sv]
package srfp_pkg;

  // ascii codes of the reply frame
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] ID_DIGITS    = 3'd3;
  localparam logic [2:0] PULSE_DIGITS = 3'd4;

  // pulse clamp limits and span of the clamped range
  localparam logic [13:0] PULSE_MIN  = 14'd500;
  localparam logic [13:0] PULSE_MAX  = 14'd2500;
  localparam logic [10:0] PULSE_SPAN = 11'd2000;

  // angle = floor(offset * 27 / 20) = (offset * 27 * ceil(2^20 / 20)) >> 20
  localparam logic [20:0] ANGLE_RECIP = 21'd1415583;
  localparam int          ANGLE_SHIFT = 20;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ID    = 3'd1,
    PH_PULSE = 3'd2
  } srfp_phase_t;

  // closed frame handed from the parser to the result stage
  typedef struct packed {
    logic        ok;
    logic [9:0]  id;
    logic [10:0] offset;
  } srfp_frame_t;

endpackage

[rtl/srfp_byte_parser.sv]
module srfp_byte_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  input  logic [7:0]           byte_data,
  output logic                 byte_ready,
  output logic                 frame_valid,
  output srfp_pkg::srfp_frame_t frame,
  input  logic                 frame_ready
);
  import srfp_pkg::*;

  srfp_phase_t phase, phase_next;
  logic [2:0]  digit_count, digit_count_next;
  logic [9:0]  id_accum, id_accum_next;
  logic [13:0] pulse_accum, pulse_accum_next;
  logic        format_error, format_error_next;

  logic        take;
  logic        is_digit;
  logic [3:0]  digit;
  logic        closing;
  logic        frame_ok;
  logic [13:0] id_scaled;
  logic [10:0] offset;
  srfp_frame_t frame_next;

  // a byte moves on once the frame slot is free or being drained
  assign byte_ready = !frame_valid || frame_ready;
  assign take       = byte_valid && byte_ready;

  assign is_digit  = (byte_data >= CH_ZERO) && (byte_data <= CH_NINE);
  assign digit     = is_digit ? byte_data[3:0] : 4'd0;
  assign id_scaled = {4'd0, id_accum} * 14'd10 + {10'd0, digit};

  // clamp the pulse and shift it down to an offset from the minimum
  always_comb begin
    if (pulse_accum < PULSE_MIN) begin
      offset = 11'd0;
    end else if (pulse_accum > PULSE_MAX) begin
      offset = PULSE_SPAN;
    end else begin
      offset = 11'(pulse_accum - PULSE_MIN);
    end
  end

  // frame state machine, one byte per step
  always_comb begin
    phase_next        = phase;
    digit_count_next  = digit_count;
    id_accum_next     = id_accum;
    pulse_accum_next  = pulse_accum;
    format_error_next = format_error;
    closing           = 1'b0;
    frame_ok          = (phase == PH_PULSE) && (digit_count == PULSE_DIGITS) && !format_error;

    if (byte_data == CH_HASH) begin
      phase_next        = PH_ID;
      digit_count_next  = 3'd0;
      id_accum_next     = 10'd0;
      pulse_accum_next  = 14'd0;
      format_error_next = 1'b0;
    end else if (phase != PH_IDLE && byte_data == CH_BANG) begin
      closing           = 1'b1;
      phase_next        = PH_IDLE;
      digit_count_next  = 3'd0;
      id_accum_next     = 10'd0;
      pulse_accum_next  = 14'd0;
      format_error_next = 1'b0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
        end
        PH_ID: begin
          if (is_digit && digit_count < ID_DIGITS) begin
            id_accum_next    = id_scaled[9:0];
            digit_count_next = digit_count + 3'd1;
          end else if (byte_data == CH_P && digit_count == ID_DIGITS) begin
            phase_next       = PH_PULSE;
            digit_count_next = 3'd0;
          end else begin
            format_error_next = 1'b1;
          end
        end
        PH_PULSE: begin
          if (is_digit && digit_count < PULSE_DIGITS) begin
            pulse_accum_next = pulse_accum * 14'd10 + {10'd0, digit};
            digit_count_next = digit_count + 3'd1;
          end else begin
            format_error_next = 1'b1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    // malformed frames report zeros
    frame_next.ok     = frame_ok;
    frame_next.id     = frame_ok ? id_accum : 10'd0;
    frame_next.offset = frame_ok ? offset : 11'd0;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      digit_count  <= 3'd0;
      id_accum     <= 10'd0;
      pulse_accum  <= 14'd0;
      format_error <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      digit_count  <= digit_count_next;
      id_accum     <= id_accum_next;
      pulse_accum  <= pulse_accum_next;
      format_error <= format_error_next;
    end
  end

  // closed frame slot
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (byte_ready) begin
      frame_valid <= take && closing;
    end
  end

  always_ff @(posedge clk) begin
    if (take && closing) begin
      frame <= frame_next;
    end
  end

endmodule

[rtl/srfp_result_stage.sv]
module srfp_result_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            own_id,
  input  logic                  frame_valid,
  input  srfp_pkg::srfp_frame_t frame,
  output logic                  frame_ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  frame_ok,
  output logic [9:0]            frame_id,
  output logic                  id_match,
  output logic [11:0]           angle_tenths
);
  import srfp_pkg::*;

  logic [31:0] angle_product;
  logic        load;

  // scale the pulse offset by 27/20 with a reciprocal multiply
  assign angle_product = {21'd0, frame.offset} * {11'd0, ANGLE_RECIP};

  assign frame_ready = !out_valid || !out_stall;
  assign load        = frame_valid && frame_ready;

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_ready) begin
      out_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_ok     <= frame.ok;
      frame_id     <= frame.id;
      id_match     <= frame.ok && (frame.id[7:0] == own_id);
      angle_tenths <= angle_product[ANGLE_SHIFT +: 12];
    end
  end

endmodule

[rtl/servo_reply_frame_parser.sv]
// servo reply frame parser: '#', three id digits, 'P', four pulse digits, '!'
// a closing '!' beat passes the input byte, frame slot and result registers before it shows as a result
// throughput: one byte per cycle unless out_stall holds a result beat, set by the input, frame and result registers
// reset: synchronous, clears the frame state, all valid flags and own_id to 0
`include "servo_reply_frame_parser_macros.svh"

module servo_reply_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        frame_ok,
  output logic [9:0]  frame_id,
  output logic        id_match,
  output logic [11:0] angle_tenths
);
  import srfp_pkg::*;

  logic [7:0]  own_id;
  logic        byte_valid;
  logic [7:0]  byte_data;
  logic        byte_ready;
  logic        in_ready;
  logic        frame_valid;
  logic        frame_ready;
  srfp_frame_t frame;
  logic        result_zero;

  // configuration register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      own_id <= cfg_data;
    end
  end

  // input byte register
  assign in_ready = !byte_valid || byte_ready;
  assign in_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_data <= rx_byte;
    end
  end

  srfp_byte_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_data   (byte_data),
    .byte_ready  (byte_ready),
    .frame_valid (frame_valid),
    .frame       (frame),
    .frame_ready (frame_ready)
  );

  srfp_result_stage u_result (
    .clk          (clk),
    .rst          (rst),
    .own_id       (own_id),
    .frame_valid  (frame_valid),
    .frame        (frame),
    .frame_ready  (frame_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_ok     (frame_ok),
    .frame_id     (frame_id),
    .id_match     (id_match),
    .angle_tenths (angle_tenths)
  );

  // every reported field other than the ok flag is zero
  assign result_zero = (frame_id == 10'd0) && !id_match && (angle_tenths == 12'd0);

  // malformed frames carry only zeros
  `SRFP_ASSERT_IMP(a_bad_frame_zero, out_valid && !frame_ok, result_zero)
  // clamped angle never leaves its range
  `SRFP_ASSERT_IMP(a_angle_range, out_valid && frame_ok, angle_tenths <= 12'd2700)
  // input backs up only behind a held result beat
  `SRFP_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall && frame_valid)
  // a config write lands in the next cycle
  `SRFP_ASSERT_NXT(a_cfg_write, cfg_valid && cfg_ready, own_id == $past(cfg_data))

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import srfp_pkg::*;

  // one closed frame as seen on the result port
  typedef struct packed {
    logic        ok;
    logic [9:0]  id;
    logic        id_hit;
    logic [11:0] angle;
  } reply_t;

  // bit-exact frame parser copy plus the queue of replies it predicts
  class frame_scoreboard;
    logic [7:0]  own_id;
    srfp_phase_t phase;
    logic [2:0]  digits;
    logic [9:0]  id_acc;
    logic [13:0] pulse_acc;
    logic        broken;
    reply_t      replies_due[$];
    int          mismatches;

    function new();
      own_id     = 8'd0;
      phase      = PH_IDLE;
      digits     = 3'd0;
      id_acc     = 10'd0;
      pulse_acc  = 14'd0;
      broken     = 1'b0;
      mismatches = 0;
    endfunction

    function void clear_frame(srfp_phase_t next_phase);
      phase     = next_phase;
      digits    = 3'd0;
      id_acc    = 10'd0;
      pulse_acc = 14'd0;
      broken    = 1'b0;
    endfunction

    // accepted input beat: advance the parser, queue a reply on a closing bang
    function void note_byte(logic [7:0] c);
      logic   is_digit;
      int     d;
      int     p;
      reply_t r;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      d = is_digit ? int'(c - CH_ZERO) : 0;
      if (c == CH_HASH) begin
        clear_frame(PH_ID);
      end else if (phase == PH_IDLE) begin
        // stray bytes between frames are dropped
      end else if (c == CH_BANG) begin
        r = '0;
        if (phase == PH_PULSE && digits == PULSE_DIGITS && !broken) begin
          p = int'(pulse_acc);
          if (p < 500) p = 500;
          if (p > 2500) p = 2500;
          r.ok     = 1'b1;
          r.id     = id_acc;
          r.id_hit = (id_acc[7:0] == own_id);
          r.angle  = 12'(((p - 500) * 27) / 20);
        end
        replies_due.push_back(r);
        clear_frame(PH_IDLE);
      end else if (phase == PH_ID) begin
        if (is_digit && digits < ID_DIGITS) begin
          id_acc = 10'(int'(id_acc) * 10 + d);
          digits = digits + 3'd1;
        end else if (c == CH_P && digits == ID_DIGITS) begin
          phase  = PH_PULSE;
          digits = 3'd0;
        end else begin
          broken = 1'b1;
        end
      end else begin
        if (is_digit && digits < PULSE_DIGITS) begin
          pulse_acc = 14'(int'(pulse_acc) * 10 + d);
          digits    = digits + 3'd1;
        end else begin
          broken = 1'b1;
        end
      end
    endfunction

    // accepted result beat: compare with the oldest predicted reply
    function void check_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reply: ok=%0d id=%0d hit=%0d angle=%0d",
                   got.ok, got.id, got.id_hit, got.angle);
        return;
      end
      want = replies_due.pop_front();
      if (got.ok !== want.ok || got.id !== want.id || got.id_hit !== want.id_hit ||
          got.angle !== want.angle) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply mismatch: want ok=%0d id=%0d hit=%0d angle=%0d,",
                   want.ok, want.id, want.id_hit, want.angle,
                   " got ok=%0d id=%0d hit=%0d angle=%0d",
                   got.ok, got.id, got.id_hit, got.angle);
      end
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        frame_ok;
  logic [9:0]  frame_id;
  logic        id_match;
  logic [11:0] angle_tenths;

  logic        calm = 1'b0;
  logic        hold_req = 1'b0;
  int          hold_left = 0;
  int          bytes_sent = 0;
  logic [7:0]  frame_bytes[$];

  frame_scoreboard sb = new();

  servo_reply_frame_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_ok     (frame_ok),
    .frame_id     (frame_id),
    .id_match     (id_match),
    .angle_tenths (angle_tenths)
  );

  always #2 clk = ~clk;

  // run guard
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: check accepted beats, then pick the stall for the next cycle
  always @(posedge clk) begin
    reply_t got;
    if (!rst && out_valid && !out_stall) begin
      got.ok     = frame_ok;
      got.id     = frame_id;
      got.id_hit = id_match;
      got.angle  = angle_tenths;
      sb.check_reply(got);
    end
    if (hold_req) begin
      hold_left = 300;
      hold_req <= 1'b0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  // one input beat, held until accepted, then maybe a gap
  task automatic send_byte(input logic [7:0] b);
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
    if (!calm && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic write_own_id(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.own_id = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and let every predicted reply drain out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_decimal(input int v, input int n);
    int p;
    for (int i = n - 1; i >= 0; i--) begin
      p = 1;
      repeat (i) p = p * 10;
      frame_bytes.push_back(CH_ZERO + 8'((v / p) % 10));
    end
  endtask

  // well-formed reply with random id and pulse, biased to matches and clamp edges
  task automatic build_good();
    int id;
    int pulse;
    int sel;
    if ($urandom_range(0, 99) < 35) begin
      id = int'(sb.own_id) + 256 * $urandom_range(0, 3);
      if (id > 999) id = int'(sb.own_id);
    end else begin
      id = $urandom_range(0, 999);
    end
    sel = $urandom_range(0, 4);
    case (sel)
      0: pulse = $urandom_range(0, 499);
      1: pulse = $urandom_range(400, 600);
      2: pulse = $urandom_range(2400, 2600);
      3: pulse = $urandom_range(2501, 9999);
      default: pulse = $urandom_range(0, 9999);
    endcase
    frame_bytes.push_back(CH_HASH);
    push_decimal(id, 3);
    frame_bytes.push_back(CH_P);
    push_decimal(pulse, 4);
    frame_bytes.push_back(CH_BANG);
  endtask

  // one random frame: mostly good, some corrupted, truncated, restarted or noise
  task automatic send_random_frame(input bit clean);
    logic [7:0] specials[4];
    logic [7:0] prefix[$];
    logic [7:0] b;
    int pick;
    int k;
    specials[0] = CH_P;
    specials[1] = CH_BANG;
    specials[2] = CH_HASH;
    specials[3] = CH_ZERO + 8'd5;
    pick = clean ? 0 : $urandom_range(0, 99);
    frame_bytes.delete();
    if (pick >= 90) begin
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      build_good();
      b = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255))
                                      : specials[$urandom_range(0, 3)];
      if (pick >= 60 && pick < 65) begin
        frame_bytes[$urandom_range(1, 8)] = b;
      end else if (pick >= 65 && pick < 70) begin
        frame_bytes.insert($urandom_range(1, 9), b);
      end else if (pick >= 70 && pick < 75) begin
        frame_bytes.delete($urandom_range(1, 8));
      end else if (pick >= 75 && pick < 83) begin
        // early close after a partial frame
        k = $urandom_range(1, 8);
        while (frame_bytes.size() > k) void'(frame_bytes.pop_back());
        frame_bytes.push_back(CH_BANG);
      end else if (pick >= 83) begin
        // partial frame dropped by a new hash
        k = $urandom_range(2, 8);
        for (int i = 0; i < k; i++) prefix.push_back(frame_bytes[i]);
        frame_bytes.delete();
        build_good();
        for (int i = k - 1; i >= 0; i--) frame_bytes.push_front(prefix[i]);
      end
    end
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  task automatic run_random(input int count, input bit clean);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < count) send_random_frame(clean);
  endtask

  // main sequence
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    write_own_id(8'd255);

    // directed: idle bytes, byte extremes, high clamp, restart, low clamp,
    // early close, bad character inside a frame
    send_byte(CH_BANG);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("#255P9999!");
    send_text("#7#000P0100!");
    send_text("#9!");
    send_text("#12AP1234!");
    settle();

    write_own_id(8'd0);
    run_random(200, 1'b0);
    settle();

    // receiver holds off while good frames keep coming, then no idling at all
    write_own_id(8'($urandom_range(0, 255)));
    calm     <= 1'b1;
    hold_req <= 1'b1;
    run_random(200, 1'b1);
    settle();
    calm <= 1'b0;

    write_own_id(8'($urandom_range(1, 254)));
    run_random(250, 1'b0);
    settle();

    write_own_id(8'd255);
    run_random(200, 1'b0);
    settle();

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/srfp_pkg.sv
rtl/srfp_byte_parser.sv
rtl/srfp_result_stage.sv
rtl/servo_reply_frame_parser.sv
sim/tb_top.sv
